### rtl/sot_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sot_pkg
// Shared types, codes and widths for the shuffle order table.
// ----------------------------------------------------------------------------
package sot_pkg;

    localparam int CNT_W              = 11;
    localparam int TRK_W              = 10;
    localparam int SEED_W             = 32;
    localparam int FUNC_W             = 2;
    localparam int STAT_W             = 2;
    localparam int CFG_IDX_W          = 2;
    localparam int CFG_DATA_W         = 32;
    localparam int S_TDATA_W          = 16;
    localparam int M_TDATA_W          = 16;
    localparam int DEFAULT_MAX_TRACKS = 1024;
    localparam int MIN_TRACKS         = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRACK_COUNT = 2'd0,
        REG_EXCLUDED    = 2'd1,
        REG_SEED        = 2'd2
    } sot_reg_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_BUILD = 2'd0,
        FUNC_GET   = 2'd1,
        FUNC_SET   = 2'd2
    } sot_func_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_END       = 2'd1,
        STAT_ERROR     = 2'd2,
        STAT_TOO_SMALL = 2'd3
    } sot_status_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_INC,
        IDX_SHUF,
        IDX_DEC
    } sot_idx_op_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_FILL,
        WR_I,
        WR_J
    } sot_wr_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FILL,
        S_DRAW,
        S_DIV,
        S_READ,
        S_WR_I,
        S_WR_J,
        S_GET,
        S_RESP
    } sot_state_t;

    typedef struct packed {
        logic        cap;
        logic        gen_load;
        logic        draw;
        sot_idx_op_t idx_op;
        sot_wr_op_t  wr_op;
        logic        rd_pair;
        logic        rd_play;
        logic        clear_built;
        logic        commit;
        logic        set_pos;
        logic        res_load;
        sot_status_t res_status;
        logic        res_use_mem;
        logic        out_load;
    } sot_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              too_small;
        logic              cfg_bad;
        logic              built;
        logic              pos_ok;
        logic              at_end;
        logic              fill_last;
        logic              n_is_two;
        logic              shuf_done;
        logic              div_done;
        logic              out_free;
    } sot_stat_t;

endpackage
`default_nettype wire

### rtl/sot_mod_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sot_mod_unit
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module sot_mod_unit (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [sot_pkg::SEED_W-1:0] dividend,
    input  wire logic [sot_pkg::CNT_W-1:0]  divisor,
    output logic                           done,
    output logic [sot_pkg::CNT_W-1:0]      remainder
);
    import sot_pkg::*;

    localparam int STEP_W = $clog2(SEED_W);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SEED_W-1:0] dvd_reg, dvd_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W:0]    rem_reg, rem_next;
    logic [CNT_W:0]    shifted;

    always_comb begin
        shifted   = {rem_reg[CNT_W-1:0], dvd_reg[SEED_W-1]};
        busy_next = busy_reg;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next  = {dvd_reg[SEED_W-2:0], 1'b0};
            rem_next  = (shifted >= {1'b0, dvs_reg}) ? shifted - {1'b0, dvs_reg} : shifted;
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(SEED_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = !busy_reg;
    assign remainder = rem_reg[CNT_W-1:0];

endmodule
`default_nettype wire

### rtl/sot_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sot_ctrl
// Command sequencer: decode, table fill, shuffle swaps and result hand-off.
// ----------------------------------------------------------------------------
module sot_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire sot_pkg::sot_stat_t stat,
    output sot_pkg::sot_cmd_t       cmd
);
    import sot_pkg::*;

    sot_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.cap    = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next   = S_RESP;
                cmd.res_load = 1'b1;
                unique case (stat.func)
                    FUNC_BUILD: begin
                        if (stat.too_small) begin
                            cmd.res_status = STAT_TOO_SMALL;
                        end else if (stat.cfg_bad) begin
                            cmd.clear_built = 1'b1;
                            cmd.res_status  = STAT_ERROR;
                        end else begin
                            cmd.res_load = 1'b0;
                            cmd.gen_load = 1'b1;
                            cmd.idx_op   = IDX_ZERO;
                            state_next   = S_FILL;
                        end
                    end
                    FUNC_GET: begin
                        if (!stat.built) begin
                            cmd.res_status = STAT_ERROR;
                        end else if (stat.at_end) begin
                            cmd.res_status = STAT_END;
                        end else begin
                            cmd.res_load = 1'b0;
                            cmd.rd_play  = 1'b1;
                            state_next   = S_GET;
                        end
                    end
                    FUNC_SET: begin
                        if (stat.built && stat.pos_ok) begin
                            cmd.set_pos    = 1'b1;
                            cmd.res_status = STAT_OK;
                        end else begin
                            cmd.res_status = STAT_ERROR;
                        end
                    end
                    default: begin
                        cmd.res_status = STAT_ERROR;
                    end
                endcase
            end
            S_FILL: begin
                cmd.wr_op = WR_FILL;
                if (stat.fill_last) begin
                    if (stat.n_is_two) begin
                        cmd.commit     = 1'b1;
                        cmd.res_load   = 1'b1;
                        cmd.res_status = STAT_OK;
                        state_next     = S_RESP;
                    end else begin
                        cmd.idx_op = IDX_SHUF;
                        state_next = S_DRAW;
                    end
                end else begin
                    cmd.idx_op = IDX_INC;
                end
            end
            S_DRAW: begin
                cmd.draw   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (stat.div_done) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd.rd_pair = 1'b1;
                state_next  = S_WR_I;
            end
            S_WR_I: begin
                cmd.wr_op  = WR_I;
                state_next = S_WR_J;
            end
            S_WR_J: begin
                cmd.wr_op = WR_J;
                if (stat.shuf_done) begin
                    cmd.commit     = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = STAT_OK;
                    state_next     = S_RESP;
                end else begin
                    cmd.idx_op = IDX_DEC;
                    state_next = S_DRAW;
                end
            end
            S_GET: begin
                cmd.res_load    = 1'b1;
                cmd.res_status  = STAT_OK;
                cmd.res_use_mem = 1'b1;
                state_next      = S_RESP;
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/sot_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sot_datapath
// Config registers, play state, xorshift generator, order memory and
// output register.
// ----------------------------------------------------------------------------
module sot_datapath #(
    parameter int MAX_TRACKS = sot_pkg::DEFAULT_MAX_TRACKS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [sot_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sot_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [sot_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [sot_pkg::M_TDATA_W-1:0]      m_tdata,
    input  wire sot_pkg::sot_cmd_t             cmd,
    output sot_pkg::sot_stat_t                 stat
);
    import sot_pkg::*;

    localparam int AW = $clog2(MAX_TRACKS);

    logic [CNT_W-1:0]  track_count_reg;
    logic [TRK_W-1:0]  excluded_reg;
    logic [SEED_W-1:0] seed_reg;

    logic [FUNC_W-1:0] func_reg;
    logic [TRK_W-1:0]  pos_reg;

    logic [CNT_W-1:0]  play_reg;
    logic [CNT_W-1:0]  live_reg;
    logic              built_reg;
    logic [SEED_W-1:0] gen_reg;
    logic [CNT_W-1:0]  idx_reg, idx_next;

    logic [TRK_W-1:0]  mem [MAX_TRACKS];
    logic [TRK_W-1:0]  rd_a_reg, rd_b_reg;

    logic [STAT_W-1:0] res_status_reg;
    logic [TRK_W-1:0]  res_track_reg;
    logic              m_tvalid_reg;
    logic [STAT_W-1:0] m_status_reg;
    logic [TRK_W-1:0]  m_track_reg;

    logic [CNT_W-1:0]  n_minus_1;
    logic [SEED_W-1:0] gen_step;
    logic              div_done;
    logic [CNT_W-1:0]  j_idx;
    logic [TRK_W-1:0]  fill_val;
    logic [AW-1:0]     wr_addr;
    logic [TRK_W-1:0]  wr_data;
    logic [AW-1:0]     rd_a_addr;

    function automatic logic [SEED_W-1:0] xorshift(input logic [SEED_W-1:0] x);
        logic [SEED_W-1:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

    assign n_minus_1 = track_count_reg - 1'b1;
    assign gen_step  = xorshift(gen_reg);

    sot_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.draw),
        .dividend  (gen_step),
        .divisor   (idx_reg + 1'b1),
        .done      (div_done),
        .remainder (j_idx)
    );

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_count_reg <= '0;
            excluded_reg    <= '0;
            seed_reg        <= SEED_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TRACK_COUNT: track_count_reg <= cfg_wdata[CNT_W-1:0];
                REG_EXCLUDED:    excluded_reg    <= cfg_wdata[TRK_W-1:0];
                REG_SEED:        seed_reg        <= cfg_wdata[SEED_W-1:0];
                default:         ;
            endcase
        end
    end

    // captured command
    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            func_reg <= s_tdata[FUNC_W-1:0];
            pos_reg  <= s_tdata[FUNC_W +: TRK_W];
        end
    end

    // play state and generator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            play_reg  <= '0;
            live_reg  <= '0;
            built_reg <= 1'b0;
            gen_reg   <= SEED_W'(1);
        end else begin
            if (cmd.clear_built) begin
                built_reg <= 1'b0;
            end
            if (cmd.commit) begin
                play_reg  <= '0;
                live_reg  <= n_minus_1;
                built_reg <= 1'b1;
            end
            if (cmd.set_pos) begin
                play_reg <= {1'b0, pos_reg};
            end
            if (cmd.gen_load) begin
                gen_reg <= seed_reg;
            end else if (cmd.draw) begin
                gen_reg <= gen_step;
            end
        end
    end

    always_comb begin
        idx_next = idx_reg;
        case (cmd.idx_op)
            IDX_ZERO: idx_next = '0;
            IDX_INC:  idx_next = idx_reg + 1'b1;
            IDX_SHUF: idx_next = track_count_reg - CNT_W'(2);
            IDX_DEC:  idx_next = idx_reg - 1'b1;
            default:  idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
    end

    // order memory: one write port, two registered read ports
    always_comb begin
        if (idx_reg == {1'b0, excluded_reg}) begin
            fill_val = n_minus_1[TRK_W-1:0];
        end else if (idx_reg == n_minus_1) begin
            fill_val = excluded_reg;
        end else begin
            fill_val = idx_reg[TRK_W-1:0];
        end
        wr_addr = AW'(idx_reg);
        wr_data = fill_val;
        case (cmd.wr_op)
            WR_I: wr_data = rd_b_reg;
            WR_J: begin
                wr_addr = AW'(j_idx);
                wr_data = rd_a_reg;
            end
            default: ;
        endcase
        rd_a_addr = cmd.rd_pair ? AW'(idx_reg) : AW'(play_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_op != WR_NONE) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_pair || cmd.rd_play) begin
            rd_a_reg <= mem[rd_a_addr];
        end
        if (cmd.rd_pair) begin
            rd_b_reg <= mem[AW'(j_idx)];
        end
    end

    // result and output register
    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_status;
            res_track_reg  <= cmd.res_use_mem ? rd_a_reg : '0;
        end
        if (cmd.out_load) begin
            m_status_reg <= res_status_reg;
            m_track_reg  <= res_track_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - STAT_W - TRK_W){1'b0}}, m_track_reg, m_status_reg};

    always_comb begin
        stat.func      = func_reg;
        stat.too_small = track_count_reg < CNT_W'(MIN_TRACKS);
        stat.cfg_bad   = (int'(track_count_reg) > MAX_TRACKS)
                       || ({1'b0, excluded_reg} >= track_count_reg);
        stat.built     = built_reg;
        stat.pos_ok    = {1'b0, pos_reg} < live_reg;
        stat.at_end    = play_reg >= live_reg;
        stat.fill_last = idx_reg == n_minus_1;
        stat.n_is_two  = track_count_reg == CNT_W'(MIN_TRACKS);
        stat.shuf_done = idx_reg == CNT_W'(1);
        stat.div_done  = div_done;
        stat.out_free  = !m_tvalid_reg || m_tready;
    end

endmodule
`default_nettype wire

### rtl/shuffle_order_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shuffle_order_table
// Builds a shuffled play order in an on-chip table and walks it.
// ----------------------------------------------------------------------------
// Usage: write track_count, excluded_track and random_seed on the cfg port
// while idle, then send items on s_ (func, position); each item gives one
// result item on m_ (status, track_index). One item is worked at a time.
// m_tvalid rises after states DECODE, GET and RESP for a good get, after
// DECODE and RESP for set and failed checks; s_tready is back in the same
// cycle that m_tvalid rises in.
// A build for n tracks first fills the table through its single write port,
// then for each of the n - 2 swaps takes one xorshift step, waits on the
// bit-serial remainder unit and does a read and two writes on the table.
// The next item is accepted once the previous result sits in the output
// register; a stalled receiver holds that result and blocks the following
// one from leaving, not from being accepted.
// Reset clears the play position, length, built flag and generator; the
// table itself needs no clearing since only built entries are read.
// ----------------------------------------------------------------------------
module shuffle_order_table #(
    parameter int MAX_TRACKS = sot_pkg::DEFAULT_MAX_TRACKS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [sot_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sot_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [sot_pkg::S_TDATA_W-1:0]  s_tdata,   // func, position
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [sot_pkg::M_TDATA_W-1:0]      m_tdata    // status, track_index
);
    import sot_pkg::*;

    sot_cmd_t  cmd;
    sot_stat_t stat;

    sot_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sot_datapath #(
        .MAX_TRACKS (MAX_TRACKS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
`default_nettype wire

### rtl/sot_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sot_checker
// Port-level checks on the shuffle order table, bound to the top level.
// ----------------------------------------------------------------------------
module sot_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [sot_pkg::M_TDATA_W-1:0] m_tdata
);
    import sot_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // only an OK result can carry a track
    a_track_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[STAT_W-1:0] != STAT_OK) |-> m_tdata[STAT_W +: TRK_W] == '0)
        else $error("track on a non-ok result");

    // one item in flight
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    // reset empties the output
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind shuffle_order_table sot_checker u_sot_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shuffle_order_table testbench
// Drives build, get and set commands with random gaps on both streams,
// rewrites the track count, excluded track and seed between phases, and
// checks every answer against a cycle-free predictor of the play order.
// ----------------------------------------------------------------------------
module testbench;

    import sot_pkg::*;

    localparam int MAX_TRACKS     = DEFAULT_MAX_TRACKS;
    localparam int LONG_HOLD      = 150;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [TRK_W-1:0]  pos;
    } cmd_t;

    typedef struct packed {
        sot_status_t      status;
        logic [TRK_W-1:0] track;
    } answer_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    // configuration as the block holds it
    logic [CNT_W-1:0]  cfg_count = '0;
    logic [TRK_W-1:0]  cfg_excl  = '0;
    logic [SEED_W-1:0] cfg_seed  = 1;

    // predicted block state
    logic [TRK_W-1:0]  order_mem [MAX_TRACKS];
    logic [CNT_W-1:0]  play_pos = '0;
    logic [CNT_W-1:0]  live_len = '0;
    logic              built    = 1'b0;
    logic [SEED_W-1:0] rng      = 1;

    cmd_t    cmd_q[$];
    answer_t due_answers[$];
    int      issued_count   = 0;
    int      accepted_count = 0;
    int      mismatches     = 0;
    logic    quiet          = 1'b0;
    logic    long_hold_arm  = 1'b0;
    int      send_gap       = 0;
    int      stall_left     = 0;
    int      hold_left      = 0;
    logic    hold_done      = 1'b0;
    int      idle_cycles    = 0;

    shuffle_order_table i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic answer_t play_order_step(logic [FUNC_W-1:0] func,
                                                logic [TRK_W-1:0] pos);
        answer_t          a;
        int unsigned      n;
        int unsigned      k;
        int unsigned      i;
        int unsigned      j;
        logic [TRK_W-1:0] t;
        a.status = STAT_ERROR;
        a.track  = '0;
        case (func)
            FUNC_BUILD: begin
                if (cfg_count < MIN_TRACKS) begin
                    a.status = STAT_TOO_SMALL;
                end else if (cfg_count > MAX_TRACKS || cfg_excl >= cfg_count) begin
                    built = 1'b0;
                end else begin
                    n   = cfg_count;
                    rng = cfg_seed;
                    for (k = 0; k < n; k++) begin
                        order_mem[TRK_W'(k)] = TRK_W'(k);
                    end
                    order_mem[TRK_W'(n-1)] = cfg_excl;
                    order_mem[cfg_excl]    = TRK_W'(n - 1);
                    n = n - 1;
                    for (i = n - 1; i > 0; i--) begin
                        rng = rng ^ (rng << 13);
                        rng = rng ^ (rng >> 17);
                        rng = rng ^ (rng << 5);
                        j = rng % (i + 1);
                        t                    = order_mem[TRK_W'(i)];
                        order_mem[TRK_W'(i)] = order_mem[TRK_W'(j)];
                        order_mem[TRK_W'(j)] = t;
                    end
                    play_pos = '0;
                    live_len = CNT_W'(n);
                    built    = 1'b1;
                    a.status = STAT_OK;
                end
            end
            FUNC_GET: begin
                if (!built) begin
                    a.status = STAT_ERROR;
                end else if (play_pos >= live_len) begin
                    a.status = STAT_END;
                end else begin
                    a.status = STAT_OK;
                    a.track  = order_mem[play_pos[TRK_W-1:0]];
                end
            end
            FUNC_SET: begin
                if (built && pos < live_len) begin
                    play_pos = CNT_W'(pos);
                    a.status = STAT_OK;
                end
            end
            default: begin
                a.status = STAT_ERROR;
            end
        endcase
        return a;
    endfunction

    // sender
    always @(posedge aclk) begin : send_proc
        cmd_t c;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                due_answers.push_back(play_order_step(s_tdata[FUNC_W-1:0],
                                                      s_tdata[FUNC_W+TRK_W-1:FUNC_W]));
                accepted_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (cmd_q.size() > 0 && !quiet && $urandom_range(0, 7) == 0) begin
                    send_gap <= $urandom_range(0, 2);
                    s_tvalid <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    c = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_TDATA_W-FUNC_W-TRK_W){1'b0}}, c.pos, c.func};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and answer check
    always @(posedge aclk) begin : sink_proc
        answer_t want;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
            hold_done  <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_answers.size() == 0) begin
                    $display("%0t: unexpected item: expected none, got status %0d track %0d",
                             $time, m_tdata[STAT_W-1:0], m_tdata[STAT_W+TRK_W-1:STAT_W]);
                    mismatches++;
                end else begin
                    want = due_answers.pop_front();
                    if (m_tdata[STAT_W-1:0] !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, m_tdata[STAT_W-1:0]);
                        mismatches++;
                    end
                    if (m_tdata[STAT_W+TRK_W-1:STAT_W] !== want.track) begin
                        $display("%0t: track_index mismatch: expected %0d, got %0d",
                                 $time, want.track, m_tdata[STAT_W+TRK_W-1:STAT_W]);
                        mismatches++;
                    end
                end
            end
            if (long_hold_arm && !hold_done && m_tvalid) begin
                hold_done <= 1'b1;
                hold_left <= LONG_HOLD;
                m_tready  <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_left <= $urandom_range(0, 2);
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("shuffle_order_table regression: fail");
            $finish;
        end
    end

    task automatic push_cmd(logic [FUNC_W-1:0] f, logic [TRK_W-1:0] p);
        cmd_q.push_back(cmd_t'{f, p});
        issued_count++;
    endtask

    task automatic drain();
        while (accepted_count != issued_count || due_answers.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_reg(sot_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_TRACK_COUNT: cfg_count = val[CNT_W-1:0];
            REG_EXCLUDED:    cfg_excl  = val[TRK_W-1:0];
            default:         cfg_seed  = val[SEED_W-1:0];
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(int unsigned cnt, int unsigned excl, logic [SEED_W-1:0] seed);
        drain();
        set_reg(REG_TRACK_COUNT, cnt);
        set_reg(REG_EXCLUDED, excl);
        set_reg(REG_SEED, seed);
    endtask

    initial begin : stim_proc
        int unsigned       pick;
        int unsigned       cnt;
        int unsigned       excl;
        int unsigned       live_guess;
        int unsigned       n_items;
        int unsigned       r;
        int                random_items;
        int                phase;
        logic [SEED_W-1:0] seed;
        random_items = 0;
        phase        = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // nothing built yet, reset configuration
        push_cmd(FUNC_GET, '0);
        push_cmd(FUNC_SET, '1);
        push_cmd(FUNC_UNUSED, '1);
        push_cmd(FUNC_BUILD, '0);
        // too few tracks
        configure(1, 0, 1);
        push_cmd(FUNC_BUILD, '0);
        // count over capacity
        configure(2047, 0, 1);
        push_cmd(FUNC_BUILD, '0);
        // excluded track past the count
        configure(5, 5, 7);
        push_cmd(FUNC_BUILD, '0);
        push_cmd(FUNC_GET, '0);
        // full table
        configure(MAX_TRACKS, 1023, '1);
        push_cmd(FUNC_BUILD, '1);
        push_cmd(FUNC_GET, '0);
        push_cmd(FUNC_SET, 10'd1022);
        push_cmd(FUNC_GET, '0);
        push_cmd(FUNC_SET, 10'd1023);
        push_cmd(FUNC_GET, '0);
        // too few tracks keeps the earlier order
        configure(0, 0, 1);
        push_cmd(FUNC_BUILD, '0);
        push_cmd(FUNC_GET, '0);
        // zero seed, two tracks
        configure(2, 0, 0);
        push_cmd(FUNC_BUILD, '0);
        push_cmd(FUNC_GET, '0);
        push_cmd(FUNC_SET, 10'd1);
        push_cmd(FUNC_SET, 10'd0);
        push_cmd(FUNC_GET, '0);
        // zero seed, excluded track already last
        configure(7, 6, 0);
        push_cmd(FUNC_BUILD, '0);
        push_cmd(FUNC_GET, '0);
        push_cmd(FUNC_SET, 10'd5);
        push_cmd(FUNC_GET, '0);

        while (random_items < 750) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                cnt = $urandom_range(0, 1);
            end else if (pick == 1) begin
                cnt = $urandom_range(MAX_TRACKS + 1, 2047);
            end else if (pick == 2) begin
                cnt = $urandom_range(100, MAX_TRACKS);
            end else begin
                cnt = $urandom_range(2, 48);
            end
            if (cnt >= 1 && cnt <= MAX_TRACKS && $urandom_range(0, 7) != 0) begin
                excl = $urandom_range(0, cnt - 1);
            end else begin
                excl = $urandom_range(0, 1023);
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                seed = '0;
            end else if (pick == 1) begin
                seed = '1;
            end else begin
                seed = $urandom;
            end
            configure(cnt, excl, seed);
            if (random_items > 650) begin
                quiet <= 1'b1;
            end
            live_guess = (cnt >= 2 && cnt <= MAX_TRACKS && excl < cnt) ? cnt - 1 : 0;
            if ($urandom_range(0, 7) != 0) begin
                push_cmd(FUNC_BUILD, TRK_W'($urandom));
            end
            n_items = $urandom_range(8, 30);
            repeat (n_items) begin
                r = $urandom_range(0, 19);
                if (r < 9) begin
                    push_cmd(FUNC_GET, TRK_W'($urandom));
                end else if (r < 15) begin
                    push_cmd(FUNC_SET, live_guess > 0 ?
                             TRK_W'($urandom_range(0, live_guess - 1)) : TRK_W'($urandom));
                end else if (r < 18) begin
                    push_cmd(FUNC_SET, TRK_W'($urandom));
                end else if (r == 18) begin
                    push_cmd(FUNC_UNUSED, TRK_W'($urandom));
                end else begin
                    push_cmd(FUNC_BUILD, TRK_W'($urandom));
                end
            end
            if (phase == 1) begin
                long_hold_arm <= 1'b1;
            end
            random_items += n_items + 1;
            phase++;
        end

        drain();
        if (mismatches == 0 && due_answers.size() == 0) begin
            $display("shuffle_order_table regression: pass");
        end else begin
            $display("shuffle_order_table regression: fail");
        end
        $finish;
    end

endmodule
